>>> hdl/esd_pkg.sv
package esd_pkg;

	localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

	localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
	localparam logic [7:0] CHAR_ZERO      = 8'h30;
	localparam logic [7:0] CHAR_SEVEN     = 8'h37;

	localparam logic KIND_TEXT = 1'b0;
	localparam logic KIND_END  = 1'b1;

	typedef struct packed {
		logic       kind;
		logic [7:0] char_in;
	} req_t;

	typedef struct packed {
		logic [7:0] char_out;
		logic       is_end;
		logic       last;
	} rsp_t;

	// One classified input: one or two results to emit, in order.
	typedef struct packed {
		logic       two;
		logic [7:0] char0;
		logic       end0;
		logic [7:0] char1;
		logic       end1;
	} cmd_t;

	typedef enum logic [2:0] {
		MODE_NORMAL = 3'b001,
		MODE_ESCAPE = 3'b010,
		MODE_OCTAL  = 3'b100
	} mode_t;

endpackage

>>> hdl/escape_sequence_decoder_unit.sv
// Decoder for C-style escape sequences, one text byte per transaction.
// The req channel carries kind (text byte or end of string) and char_in;
// the rsp channel carries char_out, is_end and last. Both use valid/stall:
// a transaction completes on a clock edge with valid high and stall low.
// The front classifies each byte against the escape/octal state and pushes
// the results it causes (none, one or two) into a small queue; the back
// drains the queue into a registered output, one result per cycle while
// the receiver does not stall. Throughput: one input per cycle while the
// queue is not full; results leave at one per cycle, set by the single
// output register. A second result (octal flush followed by a byte or end
// marker) only follows a silent octal run, so output keeps up. Results
// pass through the queue, then the output register, in order.
// req_stall rises only when the queue is full (QUEUE_DEPTH entries). When
// the receiver stalls, the output holds and the queue absorbs new results.
// Reset clears the queue and output valid and returns to normal text.
module escape_sequence_decoder_unit #(
	parameter int unsigned QUEUE_DEPTH = esd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  esd_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output esd_pkg::rsp_t rsp
);
	import esd_pkg::*;

	logic queue_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic head_valid;
	cmd_t head;

	esd_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.req_valid  (req_valid),
		.req_stall  (req_stall),
		.req        (req),
		.queue_full (queue_full),
		.push       (push),
		.push_cmd   (push_cmd)
	);

	esd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (queue_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head       (head)
	);

	esd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.rsp_valid  (rsp_valid),
		.rsp_stall  (rsp_stall),
		.rsp        (rsp)
	);

endmodule

>>> hdl/esd_front.sv
module esd_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  esd_pkg::req_t req,
	input  logic          queue_full,
	output logic          push,
	output esd_pkg::cmd_t push_cmd
);
	import esd_pkg::*;

	mode_t      mode_q, mode_d;
	logic [7:0] octal_q, octal_d;
	logic       accept;
	logic       emit;
	logic [7:0] c;

	function automatic logic [7:0] escape_map(input logic [7:0] ch);
		logic [7:0] r;
		begin
			case (ch)
				8'h61:   r = 8'd7;
				8'h62:   r = 8'd8;
				8'h66:   r = 8'd12;
				8'h6E:   r = 8'd10;
				8'h72:   r = 8'd13;
				8'h74:   r = 8'd9;
				8'h76:   r = 8'd11;
				default: r = ch;
			endcase
			return r;
		end
	endfunction

	assign req_stall = queue_full;
	assign accept    = req_valid && !queue_full;
	assign c         = req.char_in;
	assign push      = accept && emit;

	always_comb begin
		mode_d   = mode_q;
		octal_d  = octal_q;
		emit     = 1'b0;
		push_cmd = '0;
		if (req.kind == KIND_END) begin
			emit = 1'b1;
			if (mode_q == MODE_OCTAL) begin
				push_cmd.two   = 1'b1;
				push_cmd.char0 = octal_q;
				push_cmd.end1  = 1'b1;
			end else begin
				push_cmd.end0 = 1'b1;
			end
			mode_d  = MODE_NORMAL;
			octal_d = '0;
		end else begin
			unique case (mode_q)
				MODE_ESCAPE: begin
					if (c == CHAR_ZERO) begin
						mode_d  = MODE_OCTAL;
						octal_d = '0;
					end else begin
						emit           = 1'b1;
						push_cmd.char0 = escape_map(c);
						mode_d         = MODE_NORMAL;
					end
				end
				MODE_OCTAL: begin
					if (c >= CHAR_ZERO && c <= CHAR_SEVEN) begin
						octal_d = {octal_q[4:0], 3'b000} + {5'b00000, c[2:0]};
					end else begin
						// flush the run, then treat the byte as plain text or, if a backslash, as the start of an escape
						emit           = 1'b1;
						push_cmd.char0 = octal_q;
						octal_d        = '0;
						if (c == CHAR_BACKSLASH) begin
							mode_d = MODE_ESCAPE;
						end else begin
							push_cmd.two   = 1'b1;
							push_cmd.char1 = c;
							mode_d         = MODE_NORMAL;
						end
					end
				end
				default: begin
					if (c == CHAR_BACKSLASH) begin
						mode_d = MODE_ESCAPE;
					end else begin
						emit           = 1'b1;
						push_cmd.char0 = c;
						mode_d         = MODE_NORMAL;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q  <= MODE_NORMAL;
			octal_q <= '0;
		end else if (accept) begin
			mode_q  <= mode_d;
			octal_q <= octal_d;
		end
	end

endmodule

>>> hdl/esd_queue.sv
module esd_queue #(
	parameter int unsigned DEPTH = esd_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  esd_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output esd_pkg::cmd_t head
);
	import esd_pkg::*;

	localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CntW = $clog2(DEPTH + 1);
	localparam logic [PtrW-1:0] PtrLast = PtrW'(DEPTH - 1);
	localparam logic [CntW-1:0] CntFull = CntW'(DEPTH);

	cmd_t            mem [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic            do_pop;

	assign full       = (count_q == CntFull);
	assign head_valid = (count_q != '0);
	assign head       = mem[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (!push && do_pop) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

>>> hdl/esd_back.sv
module esd_back (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          head_valid,
	input  esd_pkg::cmd_t head,
	output logic          pop,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output esd_pkg::rsp_t rsp
);
	import esd_pkg::*;

	logic second_q;
	logic rsp_valid_q;
	rsp_t rsp_q;
	logic load;

	// output register is free when empty or being taken this cycle
	assign load      = head_valid && (!rsp_valid_q || !rsp_stall);
	assign pop       = load && (second_q || !head.two);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_ff @(posedge clk) begin
		if (load) begin
			if (second_q) begin
				rsp_q.char_out <= head.char1;
				rsp_q.is_end   <= head.end1;
				rsp_q.last     <= 1'b1;
			end else begin
				rsp_q.char_out <= head.char0;
				rsp_q.is_end   <= head.end0;
				rsp_q.last     <= !head.two;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
			second_q    <= 1'b0;
		end else begin
			if (load) begin
				rsp_valid_q <= 1'b1;
				second_q    <= !second_q && head.two;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

endmodule
